### src/nts_pkg.sv
// shared types and constants for the note track sequencer
package nts_pkg;

    localparam int CHANNELS_DEF = 3;
    localparam int BUFFER_BYTES_DEF = 32;

    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_DATA  = 3'd1;
    localparam logic [2:0] KIND_LOAD  = 3'd2;
    localparam logic [2:0] KIND_START = 3'd3;
    localparam logic [2:0] KIND_STOP  = 3'd4;

    localparam logic REG_TEMPO  = 1'b0;
    localparam logic REG_VOLUME = 1'b1;

    localparam logic [7:0] BYTE_END   = 8'hff;
    localparam logic [7:0] BYTE_PAUSE = 8'haa;
    localparam logic [7:0] BYTE_NOTEP = 8'h55;

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] channel;
        logic [7:0] value;
    } item_t;

    typedef struct packed {
        logic       has_note;
        logic [1:0] channel_out;
        logic [6:0] note;
        logic       silent;
        logic       underrun;
        logic       output_enabled;
        logic [3:0] started_flags;
        logic [3:0] playing_flags;
        logic       last;
    } result_t;

endpackage

### src/nts_stream_if.sv
// valid/ready channel carrying a payload
interface nts_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/nts_cfg_if.sv
// configuration write channel
interface nts_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [7:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

### src/nts_ram.sv
// generic single-port ram with registered read
module nts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 96
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### src/nts_front.sv
// input stage: takes items and queues them for the engine
module nts_front
    import nts_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic  clk,
    input  logic  rst_n,
    nts_stream_if.sink in_ch,
    output item_t q_item,
    output logic  q_valid,
    input  logic  q_pop
);
    localparam int AW = $clog2(DEPTH);
    item_t            buf_reg [DEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg;
    logic             push;

    assign in_ch.ready = (cnt_reg != (AW+1)'(DEPTH));
    assign push = in_ch.valid && in_ch.ready;
    assign q_valid = (cnt_reg != '0);
    assign q_item = buf_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wp_reg] <= in_ch.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (q_pop && q_valid)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(q_pop && q_valid);
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH)) else $error("queue count overflow");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop of empty queue");
    a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !q_pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count lost push");
endmodule

### src/nts_engine.sv
// back end: per-channel state, track fifo memory and result sequencing
module nts_engine
    import nts_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    input  item_t q_item,
    input  logic  q_valid,
    output logic  q_pop,
    nts_cfg_if.sink cfg,
    nts_stream_if.source out_ch
);
    localparam int PW = $clog2(BUFFER_BYTES);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MD = CHANNELS * BUFFER_BYTES;
    localparam int MW = $clog2(MD);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CH   = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_DEC  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;
    localparam logic [2:0] S_END  = 3'd5;

    logic [2:0]    state_reg;
    item_t         it_reg;
    logic [CW-1:0] ch_reg;
    logic [1:0]    rk_reg;     // bytes fetched for the current decode
    logic [7:0]    b_reg [3];
    logic          pend_reg;   // result waiting for the per-channel step

    logic [PW-1:0] rp_reg [CHANNELS];
    logic [PW-1:0] wp_reg [CHANNELS];
    logic [PW:0]   bc_reg [CHANNELS];
    logic [6:0]    note_reg [CHANNELS];
    logic          sil_reg [CHANNELS];
    logic [13:0]   tl_reg [CHANNELS];
    logic [13:0]   ld_reg [CHANNELS];
    logic          pp_reg [CHANNELS];
    logic [5:0]    rep_reg [CHANNELS];
    logic [7:0]    pl_reg [CHANNELS];
    logic [CHANNELS-1:0] st_reg, pb_reg;
    logic [7:0]    beat_reg, tempo_reg;
    logic          vol_reg;

    result_t       res_reg;    // result being built for the current channel
    result_t       rb_reg [CHANNELS];
    logic [CW:0]   rn_reg;     // results collected for the current item
    logic [CW-1:0] sent_reg;   // results already handed to the output
    result_t       out_reg;
    result_t       out_next;
    logic          ov_reg;

    logic          ram_we;
    logic [MW-1:0] ram_addr;
    logic [7:0]    ram_q;
    logic [CHANNELS-1:0] mask;
    logic [CHANNELS-1:0] st_after, act;
    logic [PW-1:0] rd_ptr;

    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p, input logic [1:0] k);
        logic [PW:0] s;
        s = {1'b0, p} + (PW+1)'(k);
        if (s >= (PW+1)'(BUFFER_BYTES))
        begin
            s = s - (PW+1)'(BUFFER_BYTES);
        end
        return s[PW-1:0];
    endfunction

    nts_ram #(.WIDTH(8), .DEPTH(MD)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(it_reg.value), .rdata(ram_q)
    );

    assign mask = it_reg.value[CHANNELS-1:0];
    assign cfg.ready = 1'b1;
    assign out_ch.valid = ov_reg;
    assign out_ch.data = out_reg;
    assign q_pop = (state_reg == S_IDLE) && q_valid;
    assign rd_ptr = wrap_add(rp_reg[ch_reg], rk_reg);
    assign ram_we = (state_reg == S_CH) && (it_reg.kind == KIND_DATA)
        && (32'(it_reg.channel) < CHANNELS)
        && (bc_reg[ch_reg] < (PW+1)'(BUFFER_BYTES));
    assign ram_addr = MW'(ch_reg) * MW'(BUFFER_BYTES)
        + MW'(ram_we ? wp_reg[ch_reg] : rd_ptr);

    function automatic logic [3:0] ext4(input logic [CHANNELS-1:0] v);
        logic [3:0] r;
        r = '0;
        r[CHANNELS-1:0] = v;
        return r;
    endfunction

    // decide what a tick does to one channel, given the bytes fetched
    logic        dec_need;   // another byte must be fetched first
    logic        dec_und;
    logic [1:0]  dec_pop;
    logic        d_end;
    always_comb
    begin
        dec_need = 1'b0;
        dec_und = 1'b0;
        dec_pop = '0;
        d_end = 1'b0;
        if (!pp_reg[ch_reg])
        begin
            if (bc_reg[ch_reg] == '0)
            begin
                dec_und = 1'b1;
            end
            else if (rk_reg == 2'd0)
            begin
                dec_need = 1'b1;
            end
            else if (b_reg[0] == BYTE_END)
            begin
                d_end = 1'b1;
            end
            else if (bc_reg[ch_reg] < (PW+1)'(3))
            begin
                dec_und = 1'b1;
            end
            else if (b_reg[0] >= BYTE_PAUSE)
            begin
                dec_pop = 2'd1;
            end
            else if (rk_reg == 2'd1)
            begin
                dec_need = 1'b1;
            end
            else if (rep_reg[ch_reg] != '0)
            begin
                dec_pop = 2'd1;
            end
            else if (b_reg[1][7:6] == 2'b11)
            begin
                if (rk_reg == 2'd2)
                begin
                    dec_need = 1'b1;
                end
                else
                begin
                    dec_pop = 2'd3;
                end
            end
            else
            begin
                dec_pop = 2'd2;
            end
        end
    end

    // start mask takes effect after the item for flags
    always_comb
    begin
        st_after = st_reg;
        if (it_reg.kind == KIND_START)
        begin
            st_after = st_reg | mask;
        end
        else if (it_reg.kind == KIND_STOP)
        begin
            st_after = st_reg & ~mask;
        end
        act = st_after & pb_reg;
    end

    // collected results go out after the walk, with the item's final flags
    always_comb
    begin
        out_next = '0;
        if (rn_reg != '0)
        begin
            out_next = rb_reg[sent_reg];
        end
        out_next.output_enabled = vol_reg && (act != '0);
        out_next.started_flags = ext4(st_after);
        out_next.playing_flags = ext4(pb_reg);
        out_next.last = (rn_reg == '0) || ((CW+1)'(sent_reg) == rn_reg - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DEC)
        begin
            b_reg[rk_reg - 1'b1] <= ram_q;
        end
        if (state_reg == S_OUT && pend_reg)
        begin
            rb_reg[rn_reg[CW-1:0]] <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            it_reg <= '0;
            ch_reg <= '0;
            rk_reg <= '0;
            pend_reg <= 1'b0;
            rn_reg <= '0;
            sent_reg <= '0;
            st_reg <= '0;
            pb_reg <= '0;
            beat_reg <= '0;
            tempo_reg <= '0;
            vol_reg <= 1'b1;
            ov_reg <= 1'b0;
            res_reg <= '0;
            out_reg <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                rp_reg[c] <= '0;
                wp_reg[c] <= '0;
                bc_reg[c] <= '0;
                note_reg[c] <= '0;
                sil_reg[c] <= 1'b1;
                tl_reg[c] <= '0;
                ld_reg[c] <= '0;
                pp_reg[c] <= 1'b0;
                rep_reg[c] <= '0;
                pl_reg[c] <= '0;
            end
        end
        else
        begin
            if (cfg.valid)
            begin
                if (cfg.index == REG_TEMPO)
                begin
                    tempo_reg <= cfg.wdata;
                end
                else
                begin
                    vol_reg <= cfg.wdata[0];
                end
            end
            if (out_ch.valid && out_ch.ready)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        it_reg <= q_item;
                        ch_reg <= (q_item.kind == KIND_DATA || q_item.kind == KIND_LOAD)
                            ? CW'(q_item.channel) : '0;
                        rk_reg <= '0;
                        pend_reg <= 1'b0;
                        rn_reg <= '0;
                        sent_reg <= '0;
                        state_reg <= S_CH;
                    end
                end
                S_CH:
                begin
                    state_reg <= S_END;
                    case (it_reg.kind)
                        KIND_DATA:
                        begin
                            if (ram_we)
                            begin
                                wp_reg[ch_reg] <= wrap_add(wp_reg[ch_reg], 2'd1);
                                bc_reg[ch_reg] <= bc_reg[ch_reg] + 1'b1;
                            end
                        end
                        KIND_LOAD:
                        begin
                            if (32'(it_reg.channel) < CHANNELS)
                            begin
                                rp_reg[ch_reg] <= '0;
                                wp_reg[ch_reg] <= '0;
                                bc_reg[ch_reg] <= '0;
                                tl_reg[ch_reg] <= '0;
                                ld_reg[ch_reg] <= '0;
                                pp_reg[ch_reg] <= 1'b0;
                                rep_reg[ch_reg] <= '0;
                                pl_reg[ch_reg] <= it_reg.value;
                                pb_reg[ch_reg] <= 1'b1;
                            end
                        end
                        KIND_TICK:
                        begin
                            if (beat_reg != '0)
                            begin
                                beat_reg <= beat_reg - 1'b1;
                            end
                            else
                            begin
                                beat_reg <= tempo_reg;
                                state_reg <= S_RD;
                            end
                        end
                        KIND_START, KIND_STOP:
                        begin
                            state_reg <= S_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_RD:
                begin
                    // per channel step: start/stop report, tick decode
                    if (it_reg.kind == KIND_TICK)
                    begin
                        if (!(st_reg[ch_reg] && pb_reg[ch_reg]))
                        begin
                            state_reg <= S_OUT;
                        end
                        else if (tl_reg[ch_reg] != '0)
                        begin
                            tl_reg[ch_reg] <= tl_reg[ch_reg] - 1'b1;
                            state_reg <= S_OUT;
                        end
                        else if (dec_need)
                        begin
                            rk_reg <= rk_reg + 1'b1;
                            state_reg <= S_DEC;
                        end
                        else
                        begin
                            rk_reg <= '0;
                            pend_reg <= 1'b1;
                            state_reg <= S_OUT;
                            res_reg.has_note <= 1'b1;
                            res_reg.channel_out <= 2'(ch_reg);
                            res_reg.underrun <= dec_und;
                            res_reg.note <= note_reg[ch_reg];
                            res_reg.silent <= 1'b0;
                            if (pp_reg[ch_reg])
                            begin
                                sil_reg[ch_reg] <= 1'b1;
                                tl_reg[ch_reg] <= 14'(pl_reg[ch_reg]);
                                pp_reg[ch_reg] <= 1'b0;
                                res_reg.note <= '0;
                                res_reg.silent <= 1'b1;
                            end
                            else if (d_end)
                            begin
                                sil_reg[ch_reg] <= 1'b1;
                                pb_reg[ch_reg] <= 1'b0;
                                res_reg.note <= '0;
                                res_reg.silent <= 1'b1;
                            end
                            else if (dec_und)
                            begin
                                res_reg.note <= sil_reg[ch_reg] ? '0 : note_reg[ch_reg];
                                res_reg.silent <= sil_reg[ch_reg];
                            end
                            else
                            begin
                                rp_reg[ch_reg] <= wrap_add(rp_reg[ch_reg], dec_pop);
                                bc_reg[ch_reg] <= bc_reg[ch_reg] - (PW+1)'(dec_pop);
                                if (b_reg[0] >= BYTE_PAUSE)
                                begin
                                    tl_reg[ch_reg] <= 14'(b_reg[0] - BYTE_PAUSE);
                                    sil_reg[ch_reg] <= 1'b1;
                                    res_reg.note <= '0;
                                    res_reg.silent <= 1'b1;
                                end
                                else
                                begin
                                    if (rep_reg[ch_reg] != '0)
                                    begin
                                        rep_reg[ch_reg] <= rep_reg[ch_reg] - 1'b1;
                                        tl_reg[ch_reg] <= ld_reg[ch_reg];
                                    end
                                    else if (b_reg[1][7:6] == 2'b11)
                                    begin
                                        ld_reg[ch_reg] <= {b_reg[1][5:0], b_reg[2]};
                                        tl_reg[ch_reg] <= {b_reg[1][5:0], b_reg[2]};
                                    end
                                    else if (b_reg[1][7])
                                    begin
                                        rep_reg[ch_reg] <= b_reg[1][5:0];
                                        tl_reg[ch_reg] <= ld_reg[ch_reg];
                                    end
                                    else
                                    begin
                                        ld_reg[ch_reg] <= 14'(b_reg[1]);
                                        tl_reg[ch_reg] <= 14'(b_reg[1]);
                                    end
                                    pp_reg[ch_reg] <= (b_reg[0] >= BYTE_NOTEP);
                                    note_reg[ch_reg] <= (b_reg[0] >= BYTE_NOTEP)
                                        ? 7'(b_reg[0] - BYTE_NOTEP) : b_reg[0][6:0];
                                    sil_reg[ch_reg] <= 1'b0;
                                    res_reg.note <= (b_reg[0] >= BYTE_NOTEP)
                                        ? 7'(b_reg[0] - BYTE_NOTEP) : b_reg[0][6:0];
                                end
                            end
                        end
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                        res_reg.has_note <= 1'b1;
                        res_reg.channel_out <= 2'(ch_reg);
                        res_reg.underrun <= 1'b0;
                        if (it_reg.kind == KIND_START)
                        begin
                            pend_reg <= mask[ch_reg] && (st_reg[ch_reg] || pb_reg[ch_reg]);
                            res_reg.note <= sil_reg[ch_reg] ? '0 : note_reg[ch_reg];
                            res_reg.silent <= sil_reg[ch_reg];
                        end
                        else
                        begin
                            pend_reg <= mask[ch_reg];
                            res_reg.note <= '0;
                            res_reg.silent <= 1'b1;
                        end
                    end
                end
                S_DEC:
                begin
                    // ram data for the requested byte is ready next cycle
                    state_reg <= S_RD;
                end
                S_OUT:
                begin
                    if (pend_reg)
                    begin
                        rn_reg <= rn_reg + 1'b1;
                        pend_reg <= 1'b0;
                    end
                    if (32'(ch_reg) == CHANNELS - 1)
                    begin
                        state_reg <= S_END;
                    end
                    else
                    begin
                        ch_reg <= ch_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_END:
                begin
                    if (!ov_reg || out_ch.ready)
                    begin
                        ov_reg <= 1'b1;
                        out_reg <= out_next;
                        if (out_next.last)
                        begin
                            state_reg <= S_IDLE;
                            st_reg <= st_after;
                        end
                        else
                        begin
                            sent_reg <= sent_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_bc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bc_reg[0] <= (PW+1)'(BUFFER_BYTES)) else $error("fifo count overflow");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !out_ch.ready |=> $stable(out_reg)) else $error("result changed while stalled");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == S_CH) else $error("pop without start");
endmodule

### src/note_track_sequencer_core.sv
// note track sequencer top level
// Channels: in_ch carries items (kind, channel, value); out_ch carries results,
// one or more per item with last set on the final one; cfg writes tempo
// (index 0) and volume_on (index 1), always ready. A two-entry queue parts
// the input from the engine, so items are taken while earlier ones are
// being worked. Data, load and non-beat ticks go straight from S_CH to S_END.
// A beat tick or start/stop walks the channels in turn; a decoding channel
// fetches up to three track bytes from the shared fifo memory, one read at a
// time, each through an S_RD and an S_DEC state. The results of a walk are
// collected and sent after it, at best one per cycle while the receiver is
// ready, so that every result carries the item's final flags. They leave
// through a single output register; when the receiver stalls the engine waits
// on it and the queue fills, then in_ch.ready drops. Reset clears all channel
// state, pointers and flags; fifo memory contents are undefined until written
// and are read only behind the fill counts, so no clearing pass is needed.
module note_track_sequencer_core
    import nts_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input logic clk,
    input logic rst_n,
    nts_stream_if.sink in_ch,
    nts_stream_if.source out_ch,
    nts_cfg_if.sink cfg
);
    item_t q_item;
    logic  q_valid, q_pop;

    nts_front #(.DEPTH(2)) u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop)
    );

    nts_engine #(.CHANNELS(CHANNELS), .BUFFER_BYTES(BUFFER_BYTES)) u_engine (
        .clk(clk), .rst_n(rst_n), .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop),
        .cfg(cfg), .out_ch(out_ch)
    );
endmodule
